// ===== sv/cdda_pkg.sv =====
package cdda_pkg;

    // calendar limits
    localparam int YEAR_MAX   = 9999;
    localparam int DELTA_BITS = 20;

    // field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int CNT_W   = 20;

    // signed day offset inside the month: holds day - 1 plus any delta
    localparam int ACC_W = CNT_W + 2;

    // bit that carries the sign of the delta within the day count field
    localparam int SIGN_IDX = (DELTA_BITS <= CNT_W) ? DELTA_BITS - 1 : CNT_W - 1;
    localparam bit DELTA_SIGNED = (DELTA_BITS <= CNT_W);

    // floor(y / 25) == (y * LEAP_RECIP) >> LEAP_SHIFT for every 14-bit year
    localparam int LEAP_SHIFT = 20;
    localparam int RECIP_W    = 16;
    localparam logic [RECIP_W-1:0] LEAP_RECIP = RECIP_W'(41944);
    localparam int PROD_W     = YEAR_W + RECIP_W;
    localparam int QUOT_W     = PROD_W - LEAP_SHIFT;

    localparam logic [YEAR_W-1:0]  YEAR_TOP    = YEAR_W'(YEAR_MAX);
    localparam logic [YEAR_W-1:0]  YEAR_RESET  = YEAR_W'(1900);
    localparam logic [YEAR_W-1:0]  YEAR_EPOCH  = YEAR_W'(1970);
    localparam logic [YEAR_W-1:0]  YEAR_FIRST  = YEAR_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_JAN   = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_FEB   = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_DEC   = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   DEC_DAYS    = DAY_W'(31);

    localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_ADD  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LOAD = 2'd1,
        ST_UNDER    = 2'd2,
        ST_OVER     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEAP_MUL,
        S_LEAP_REM,
        S_CHECK,
        S_ROLL,
        S_FIN
    } t_state;

    // outcome of one roll step
    typedef struct packed {
        logic               under;
        logic               over;
        logic               done;
        logic               year_chg;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [ACC_W-1:0]   acc;
    } t_roll;

    // month length, zero for codes that are not a month
    function automatic logic [DAY_W-1:0] f_month_len(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] len;
        len = MONTH_LEN[m];
        if (m == MONTH_FEB && leap) begin
            len = len + DAY_W'(1);
        end
        return len;
    endfunction

    // low DELTA_BITS bits of the day count, sign extended
    function automatic logic [ACC_W-1:0] f_delta(input logic [CNT_W-1:0] raw);
        logic [ACC_W-1:0] d;
        for (int i = 0; i < ACC_W; i++) begin
            if (i < DELTA_BITS && i < CNT_W) begin
                d[i] = raw[i];
            end else if (i < DELTA_BITS) begin
                d[i] = 1'b0;
            end else begin
                d[i] = DELTA_SIGNED ? raw[SIGN_IDX] : 1'b0;
            end
        end
        return d;
    endfunction

    // low DELTA_BITS bits of the day count, unsigned
    function automatic logic [ACC_W-1:0] f_day_raw(input logic [CNT_W-1:0] raw);
        logic [ACC_W-1:0] d;
        for (int i = 0; i < ACC_W; i++) begin
            d[i] = (i < DELTA_BITS && i < CNT_W) ? raw[i] : 1'b0;
        end
        return d;
    endfunction

endpackage

// ===== sv/cdda_leap.sv =====
module cdda_leap (
    input  logic                        i_clk,
    input  logic [cdda_pkg::YEAR_W-1:0] i_year,
    output logic                        o_leap
);

    logic [cdda_pkg::PROD_W-1:0] r_prod;
    logic [cdda_pkg::YEAR_W-1:0] r_year_d;
    logic                        r_leap;
    logic [cdda_pkg::QUOT_W-1:0] quot;
    logic [cdda_pkg::YEAR_W:0]   quot_x25;
    logic [cdda_pkg::YEAR_W:0]   rem;
    logic                        div25;
    logic                        n_leap;

    // stage one: reciprocal multiply for the divide by 25
    always_ff @(posedge i_clk) begin
        r_prod   <= cdda_pkg::PROD_W'(i_year) * cdda_pkg::PROD_W'(cdda_pkg::LEAP_RECIP);
        r_year_d <= i_year;
    end

    // stage two: remainder by shift and add, then the leap rule
    always_comb begin
        quot     = r_prod[cdda_pkg::PROD_W-1:cdda_pkg::LEAP_SHIFT];
        quot_x25 = (cdda_pkg::YEAR_W+1)'({quot, 4'b0000})
                 + (cdda_pkg::YEAR_W+1)'({quot, 3'b000})
                 + (cdda_pkg::YEAR_W+1)'(quot);
        rem      = (cdda_pkg::YEAR_W+1)'(r_year_d) - quot_x25;
        div25    = (rem == '0);
        // divisible by 4, and not by 100 unless by 400 (16 and 25)
        n_leap   = (r_year_d[1:0] == 2'b00) && (!div25 || r_year_d[3:2] == 2'b00);
    end

    always_ff @(posedge i_clk) begin
        r_leap <= n_leap;
    end

    assign o_leap = r_leap;

endmodule

// ===== sv/cdda_roll.sv =====
module cdda_roll (
    input  logic [cdda_pkg::YEAR_W-1:0]  i_year,
    input  logic [cdda_pkg::MONTH_W-1:0] i_month,
    input  logic [cdda_pkg::ACC_W-1:0]   i_acc,
    input  logic                         i_leap,
    output cdda_pkg::t_roll              o_roll
);

    logic                         neg;
    logic [cdda_pkg::DAY_W-1:0]   len_cur;
    logic [cdda_pkg::DAY_W-1:0]   len_prev;
    logic [cdda_pkg::DAY_W-1:0]   len_sel;
    logic [cdda_pkg::ACC_W-1:0]   addend;
    logic                         past_end;

    always_comb begin
        neg      = i_acc[cdda_pkg::ACC_W-1];
        len_cur  = cdda_pkg::f_month_len(i_month, i_leap);
        len_prev = cdda_pkg::f_month_len(i_month - cdda_pkg::MONTH_W'(1), i_leap);
        past_end = !neg && (i_acc >= cdda_pkg::ACC_W'(len_cur));

        // year wraps always cross december, so its length is fixed
        if (neg) begin
            len_sel = (i_month == cdda_pkg::MONTH_JAN) ? cdda_pkg::DEC_DAYS : len_prev;
        end else begin
            len_sel = (i_month == cdda_pkg::MONTH_DEC) ? cdda_pkg::DEC_DAYS : len_cur;
        end
        addend = neg ? cdda_pkg::ACC_W'(len_sel) : -cdda_pkg::ACC_W'(len_sel);

        o_roll          = '0;
        o_roll.year     = i_year;
        o_roll.month    = i_month;
        o_roll.acc      = i_acc + addend;

        if (neg) begin
            if (i_month == cdda_pkg::MONTH_JAN) begin
                if (i_year == cdda_pkg::YEAR_FIRST) begin
                    o_roll.under = 1'b1;
                end else begin
                    o_roll.year     = i_year - cdda_pkg::YEAR_W'(1);
                    o_roll.month    = cdda_pkg::MONTH_DEC;
                    o_roll.year_chg = 1'b1;
                end
            end else begin
                o_roll.month = i_month - cdda_pkg::MONTH_W'(1);
            end
        end else if (past_end) begin
            if (i_month == cdda_pkg::MONTH_DEC) begin
                if (i_year == cdda_pkg::YEAR_TOP) begin
                    o_roll.over = 1'b1;
                end else begin
                    o_roll.year     = i_year + cdda_pkg::YEAR_W'(1);
                    o_roll.month    = cdda_pkg::MONTH_JAN;
                    o_roll.year_chg = 1'b1;
                end
            end else begin
                o_roll.month = i_month + cdda_pkg::MONTH_W'(1);
            end
        end else begin
            o_roll.done = 1'b1;
        end
    end

endmodule

// ===== sv/calendar_date_day_adder.sv =====
// channel   direction  handshake                  payload
// request   in         i_in_valid / o_in_stall    i_cmd i_year_in i_month_in i_day_count
// result    out        o_out_valid / i_out_stall  o_year_out o_month_out o_day_out o_status
//
// load: leap test (S_LEAP_MUL, S_LEAP_REM), then S_CHECK and S_FIN to the result
// adjust: leap test, an S_ROLL step per month, a new leap test per year boundary
//   crossed, then S_FIN; a full 20-bit delta steps about 17,200 months and 1,400 years
// the request side stalls from acceptance until the result sits in the output register
// a stalled result is held; a new request may be accepted while it waits
// synchronous active-low reset restores 1900-01-01, no result pending
module calendar_date_day_adder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_cmd,
    input  logic [cdda_pkg::YEAR_W-1:0]  i_year_in,
    input  logic [cdda_pkg::MONTH_W-1:0] i_month_in,
    input  logic signed [cdda_pkg::CNT_W-1:0] i_day_count,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [cdda_pkg::YEAR_W-1:0]  o_year_out,
    output logic [cdda_pkg::MONTH_W-1:0] o_month_out,
    output logic [cdda_pkg::DAY_W-1:0]   o_day_out,
    output logic [1:0]                   o_status
);

    // working date: year, month and signed offset from the first of the month;
    // between requests it is the stored date with offset = day - 1
    cdda_pkg::t_state             r_state, n_state;
    logic [cdda_pkg::YEAR_W-1:0]  r_year, n_year;
    logic [cdda_pkg::MONTH_W-1:0] r_month, n_month;
    logic [cdda_pkg::ACC_W-1:0]   r_acc, n_acc;
    cdda_pkg::t_cmd               r_cmd, n_cmd;
    cdda_pkg::t_status            r_status, n_status;

    // output register
    logic                         r_out_valid, n_out_valid;
    logic [cdda_pkg::YEAR_W-1:0]  r_o_year, n_o_year;
    logic [cdda_pkg::MONTH_W-1:0] r_o_month, n_o_month;
    logic [cdda_pkg::DAY_W-1:0]   r_o_day, n_o_day;
    cdda_pkg::t_status            r_o_status, n_o_status;

    logic                         leap;
    cdda_pkg::t_roll              roll;
    logic                         accept;
    logic                         out_free;
    logic [cdda_pkg::DAY_W-1:0]   load_len;
    logic                         load_ok;

    // leap test of the working year, delayed behind it by r_prod and then r_leap
    cdda_leap u_leap (
        .i_clk  (i_clk),
        .i_year (r_year),
        .o_leap (leap)
    );

    // one month step forward or back
    cdda_roll u_roll (
        .i_year  (r_year),
        .i_month (r_month),
        .i_acc   (r_acc),
        .i_leap  (leap),
        .o_roll  (roll)
    );

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // load check: offset holds the raw day here
    assign load_len = cdda_pkg::f_month_len(r_month, leap);
    assign load_ok  = (r_year >= cdda_pkg::YEAR_FIRST) && (r_year <= cdda_pkg::YEAR_TOP)
                   && (r_acc != '0) && (r_acc <= cdda_pkg::ACC_W'(load_len));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cdda_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = cdda_pkg::S_LEAP_MUL;
                end
            end
            cdda_pkg::S_LEAP_MUL: begin
                n_state = cdda_pkg::S_LEAP_REM;
            end
            cdda_pkg::S_LEAP_REM: begin
                n_state = (r_cmd == cdda_pkg::CMD_LOAD) ? cdda_pkg::S_CHECK : cdda_pkg::S_ROLL;
            end
            cdda_pkg::S_CHECK: begin
                n_state = cdda_pkg::S_FIN;
            end
            cdda_pkg::S_ROLL: begin
                if (roll.under || roll.over || roll.done) begin
                    n_state = cdda_pkg::S_FIN;
                end else if (roll.year_chg) begin
                    // new year needs a fresh leap test
                    n_state = cdda_pkg::S_LEAP_MUL;
                end
            end
            cdda_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = cdda_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cdda_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_year      = r_year;
        n_month     = r_month;
        n_acc       = r_acc;
        n_cmd       = r_cmd;
        n_status    = r_status;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_year    = r_o_year;
        n_o_month   = r_o_month;
        n_o_day     = r_o_day;
        n_o_status  = r_o_status;
        o_in_stall  = (r_state != cdda_pkg::S_IDLE);

        case (r_state)
            cdda_pkg::S_IDLE: begin
                if (accept) begin
                    n_cmd    = cdda_pkg::t_cmd'(i_cmd);
                    n_status = cdda_pkg::ST_OK;
                    if (i_cmd == cdda_pkg::CMD_LOAD) begin
                        n_year  = i_year_in;
                        n_month = i_month_in;
                        n_acc   = cdda_pkg::f_day_raw(i_day_count);
                    end else begin
                        n_acc   = r_acc + cdda_pkg::f_delta(i_day_count);
                    end
                end
            end
            cdda_pkg::S_CHECK: begin
                if (load_ok) begin
                    n_acc = r_acc - cdda_pkg::ACC_W'(1);
                end else begin
                    // invalid load falls back to the epoch
                    n_year   = cdda_pkg::YEAR_EPOCH;
                    n_month  = cdda_pkg::MONTH_JAN;
                    n_acc    = '0;
                    n_status = cdda_pkg::ST_BAD_LOAD;
                end
            end
            cdda_pkg::S_ROLL: begin
                if (roll.under) begin
                    n_year   = cdda_pkg::YEAR_FIRST;
                    n_month  = cdda_pkg::MONTH_JAN;
                    n_acc    = '0;
                    n_status = cdda_pkg::ST_UNDER;
                end else if (roll.over) begin
                    // saturate at the last day of the last year
                    n_year   = cdda_pkg::YEAR_TOP;
                    n_month  = cdda_pkg::MONTH_DEC;
                    n_acc    = cdda_pkg::ACC_W'(cdda_pkg::DEC_DAYS) - cdda_pkg::ACC_W'(1);
                    n_status = cdda_pkg::ST_OVER;
                end else if (!roll.done) begin
                    n_year  = roll.year;
                    n_month = roll.month;
                    n_acc   = roll.acc;
                end
            end
            cdda_pkg::S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_year    = r_year;
                    n_o_month   = r_month;
                    n_o_day     = r_acc[cdda_pkg::DAY_W-1:0] + cdda_pkg::DAY_W'(1);
                    n_o_status  = r_status;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cdda_pkg::S_IDLE;
            r_year      <= cdda_pkg::YEAR_RESET;
            r_month     <= cdda_pkg::MONTH_JAN;
            r_acc       <= '0;
            r_cmd       <= cdda_pkg::CMD_LOAD;
            r_status    <= cdda_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_year      <= n_year;
            r_month     <= n_month;
            r_acc       <= n_acc;
            r_cmd       <= n_cmd;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_year   <= n_o_year;
        r_o_month  <= n_o_month;
        r_o_day    <= n_o_day;
        r_o_status <= n_o_status;
    end

    assign o_out_valid = r_out_valid;
    assign o_year_out  = r_o_year;
    assign o_month_out = r_o_month;
    assign o_day_out   = r_o_day;
    assign o_status    = r_o_status;

    // stored date between requests is always a real date
    a_idle_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdda_pkg::S_IDLE) |->
            (r_month >= cdda_pkg::MONTH_JAN && r_month <= cdda_pkg::MONTH_DEC
             && !r_acc[cdda_pkg::ACC_W-1] && r_acc < cdda_pkg::ACC_W'(31)))
        else $error("stored date out of range");

    // a finished request with a free output register is published next cycle
    a_fin_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdda_pkg::S_FIN && out_free) |=>
            (r_out_valid && r_state == cdda_pkg::S_IDLE))
        else $error("finished request not published");

    // underflow always reports the first day of year one
    a_under_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == cdda_pkg::ST_UNDER) |->
            (o_year_out == cdda_pkg::YEAR_FIRST && o_month_out == cdda_pkg::MONTH_JAN
             && o_day_out == cdda_pkg::DAY_W'(1)))
        else $error("underflow result is not the first day");

    // the roll never leaves the calendar range
    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdda_pkg::S_ROLL) |->
            (r_year >= cdda_pkg::YEAR_FIRST && r_year <= cdda_pkg::YEAR_TOP))
        else $error("roll year out of range");

endmodule

// ===== tb/calendar_date_checker.sv =====
`timescale 1ns / 1ps
module calendar_date_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic                         i_cmd,
    input  logic [cdda_pkg::YEAR_W-1:0]  i_year_in,
    input  logic [cdda_pkg::MONTH_W-1:0] i_month_in,
    input  logic [cdda_pkg::CNT_W-1:0]   i_day_count,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [cdda_pkg::YEAR_W-1:0]  i_year_out,
    input  logic [cdda_pkg::MONTH_W-1:0] i_month_out,
    input  logic [cdda_pkg::DAY_W-1:0]   i_day_out,
    input  logic [1:0]                   i_status,
    output int unsigned                  o_fail_count,
    output int unsigned                  o_pending
);

    typedef struct packed {
        logic [cdda_pkg::YEAR_W-1:0]  year;
        logic [cdda_pkg::MONTH_W-1:0] month;
        logic [cdda_pkg::DAY_W-1:0]   day;
        cdda_pkg::t_status            status;
    } t_date_result;

    localparam int unsigned COMMON_MONTH_DAYS [13] = '{
        0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
    };

    // date the block should hold right now
    int unsigned  held_year;
    int unsigned  held_month;
    int unsigned  held_day;
    t_date_result date_q [$];
    int unsigned  mismatches = 0;
    int unsigned  result_no = 0;

    assign o_fail_count = mismatches;

    function automatic bit is_leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
        int unsigned len;
        len = (m >= 1 && m <= 12) ? COMMON_MONTH_DAYS[m] : 0;
        if (m == 2 && is_leap_year(y)) begin
            len++;
        end
        return len;
    endfunction

    // days since 0001-01-01
    function automatic longint day_number(input int unsigned y, input int unsigned m,
                                          input int unsigned d);
        longint      p;
        longint      n;
        int unsigned k;
        p = longint'(y) - 1;
        n = 365 * p + p / 4 - p / 100 + p / 400;
        for (k = 1; k < m; k++) begin
            n += month_length(y, k);
        end
        return n + longint'(d) - 1;
    endfunction

    function automatic void hold_day_number(input longint n);
        longint      eras;
        longint      rest;
        longint      cent;
        longint      quads;
        longint      yrs;
        int unsigned y;
        int unsigned m;
        eras = n / 146097;
        rest = n % 146097;
        cent = rest / 36524;
        if (cent > 3) begin
            cent = 3;
        end
        rest -= cent * 36524;
        quads = rest / 1461;
        rest = rest % 1461;
        yrs = rest / 365;
        if (yrs > 3) begin
            yrs = 3;
        end
        rest -= yrs * 365;
        y = int'(1 + 400 * eras + 100 * cent + 4 * quads + yrs);
        m = 1;
        while (rest >= month_length(y, m) && m < 12) begin
            rest -= month_length(y, m);
            m++;
        end
        held_year  = y;
        held_month = m;
        held_day   = int'(rest) + 1;
    endfunction

    function automatic t_date_result apply_request(
        input logic                         cmd,
        input logic [cdda_pkg::YEAR_W-1:0]  y_in,
        input logic [cdda_pkg::MONTH_W-1:0] m_in,
        input logic [cdda_pkg::CNT_W-1:0]   raw
    );
        longint       masked;
        longint       target;
        t_date_result r;
        r.status = cdda_pkg::ST_OK;
        masked = longint'(raw) & ((64'sd1 <<< cdda_pkg::DELTA_BITS) - 1);
        if (cdda_pkg::t_cmd'(cmd) == cdda_pkg::CMD_LOAD) begin
            if (y_in >= 1 && y_in <= cdda_pkg::YEAR_MAX && m_in >= 1 && m_in <= 12 &&
                masked >= 1 && masked <= month_length(y_in, m_in)) begin
                held_year  = y_in;
                held_month = m_in;
                held_day   = int'(masked);
            end else begin
                held_year  = cdda_pkg::YEAR_EPOCH;
                held_month = cdda_pkg::MONTH_JAN;
                held_day   = 1;
                r.status   = cdda_pkg::ST_BAD_LOAD;
            end
        end else begin
            // two's complement day delta
            if (masked[cdda_pkg::DELTA_BITS-1]) begin
                masked -= 64'sd1 <<< cdda_pkg::DELTA_BITS;
            end
            target = day_number(held_year, held_month, held_day) + masked;
            if (target < 0) begin
                held_year  = cdda_pkg::YEAR_FIRST;
                held_month = cdda_pkg::MONTH_JAN;
                held_day   = 1;
                r.status   = cdda_pkg::ST_UNDER;
            end else if (target > day_number(cdda_pkg::YEAR_TOP, cdda_pkg::MONTH_DEC,
                                             cdda_pkg::DEC_DAYS)) begin
                held_year  = cdda_pkg::YEAR_TOP;
                held_month = cdda_pkg::MONTH_DEC;
                held_day   = cdda_pkg::DEC_DAYS;
                r.status   = cdda_pkg::ST_OVER;
            end else begin
                hold_day_number(target);
            end
        end
        r.year  = cdda_pkg::YEAR_W'(held_year);
        r.month = cdda_pkg::MONTH_W'(held_month);
        r.day   = cdda_pkg::DAY_W'(held_day);
        return r;
    endfunction

    task automatic report_bad(input string what);
        $display("%0t: result %0d %s", $time, result_no, what);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : watch
        t_date_result want;
        if (!i_rst_n) begin
            held_year  = cdda_pkg::YEAR_RESET;
            held_month = cdda_pkg::MONTH_JAN;
            held_day   = 1;
            date_q.delete();
        end else begin
            // results first: a result taken here belongs to an older request
            if (i_out_valid && !i_out_stall) begin
                result_no++;
                if (date_q.size() == 0) begin
                    report_bad("arrived with no request outstanding");
                end else begin
                    want = date_q.pop_front();
                    if (i_year_out !== want.year) begin
                        report_bad($sformatf("year %0d, expected %0d", i_year_out, want.year));
                    end
                    if (i_month_out !== want.month) begin
                        report_bad($sformatf("month %0d, expected %0d",
                                             i_month_out, want.month));
                    end
                    if (i_day_out !== want.day) begin
                        report_bad($sformatf("day %0d, expected %0d", i_day_out, want.day));
                    end
                    if (i_status !== want.status) begin
                        report_bad($sformatf("status %0d, expected %0d",
                                             i_status, want.status));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                date_q.push_back(apply_request(i_cmd, i_year_in, i_month_in, i_day_count));
            end
        end
        o_pending <= date_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;

    localparam int unsigned RANDOM_ITEMS  = 1600;
    localparam int unsigned MAX_WAIT      = 16;
    // margin after the drain; this covers any stray late result
    localparam int unsigned SETTLE_CYCLES = 40;
    // full-width adjustments step month by month across up to about 1,400 years, so keep them few
    localparam int unsigned WIDE_ADJUSTS  = 12;

    logic                         clk;
    logic                         rst_n;

    // request channel
    logic                         req_valid;
    logic                         req_stall;
    logic                         req_cmd;
    logic [cdda_pkg::YEAR_W-1:0]  req_year;
    logic [cdda_pkg::MONTH_W-1:0] req_month;
    logic [cdda_pkg::CNT_W-1:0]   req_days;

    // result channel
    logic                         res_valid;
    logic                         res_stall = 1'b1;
    logic [cdda_pkg::YEAR_W-1:0]  res_year;
    logic [cdda_pkg::MONTH_W-1:0] res_month;
    logic [cdda_pkg::DAY_W-1:0]   res_day;
    logic [1:0]                   res_status;

    int unsigned                  fail_count;
    int unsigned                  pending;
    int unsigned                  requests_sent = 0;
    int unsigned                  hold_left = 0;
    // when set, both sides run flat out with no idle cycles
    bit                           no_idle = 1'b0;

    calendar_date_day_adder u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_cmd       (req_cmd),
        .i_year_in   (req_year),
        .i_month_in  (req_month),
        .i_day_count (req_days),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_year_out  (res_year),
        .o_month_out (res_month),
        .o_day_out   (res_day),
        .o_status    (res_status)
    );

    // predicts every request and checks every result
    calendar_date_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (req_valid),
        .i_in_stall   (req_stall),
        .i_cmd        (req_cmd),
        .i_year_in    (req_year),
        .i_month_in   (req_month),
        .i_day_count  (req_days),
        .i_out_valid  (res_valid),
        .i_out_stall  (res_stall),
        .i_year_out   (res_year),
        .i_month_out  (res_month),
        .i_day_out    (res_day),
        .i_status     (res_status),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int unsigned draw_wait();
        return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic int signed_span(input int unsigned mag);
        return int'($urandom_range(0, 2 * mag)) - int'(mag);
    endfunction

    // result side: after each taken result, draw how many cycles the next one is held off
    // the count only runs down while a result is actually on offer
    always @(posedge clk) begin : result_backpressure
        int unsigned n;
        if (!rst_n || (res_valid && !res_stall)) begin
            n = draw_wait();
            res_stall <= (n != 0);
            hold_left <= (n != 0) ? n - 1 : 0;
        end else if (res_valid) begin
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end else begin
                res_stall <= 1'b0;
            end
        end
    end

    // one request: optional idle gap, then hold the payload until it is taken
    task automatic send_request(input cdda_pkg::t_cmd c,
                                input logic [cdda_pkg::YEAR_W-1:0] y,
                                input logic [cdda_pkg::MONTH_W-1:0] m,
                                input logic [cdda_pkg::CNT_W-1:0] dc);
        int unsigned gap;
        gap = draw_wait();
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_cmd   <= c;
        req_year  <= y;
        req_month <= m;
        req_days  <= dc;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_stall);
        requests_sent++;
    endtask

    task automatic load_date(input int unsigned y, input int unsigned m, input int unsigned d);
        send_request(cdda_pkg::CMD_LOAD, cdda_pkg::YEAR_W'(y), cdda_pkg::MONTH_W'(m),
                     cdda_pkg::CNT_W'(d));
    endtask

    // year and month fields carry junk on an adjust, they must be ignored
    task automatic add_days(input int delta);
        send_request(cdda_pkg::CMD_ADD, cdda_pkg::YEAR_W'($urandom),
                     cdda_pkg::MONTH_W'($urandom), cdda_pkg::CNT_W'(delta));
    endtask

    // bias towards leap-year corner cases and the centuries around them
    function automatic int unsigned pick_year();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(1, cdda_pkg::YEAR_MAX);
            1:       return 100 * $urandom_range(1, 99) + $urandom_range(0, 4);
            2:       return $urandom_range(1896, 2104);
            default: return 4 * $urandom_range(1, cdda_pkg::YEAR_MAX / 4);
        endcase
    endfunction

    // mostly safe days; 29 to 31 sometimes fall outside the month on purpose
    function automatic int unsigned pick_day();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 31) : $urandom_range(1, 28);
    endfunction

    function automatic int pick_delta();
        return ($urandom_range(0, 9) == 0) ? signed_span(4000) : signed_span(400);
    endfunction

    task automatic run_directed();
        add_days(0);                    // reset date comes back untouched
        load_date(2000, 2, 29);         // leap by the 400 rule
        add_days(1);
        load_date(1900, 2, 29);         // century, not leap: rejected
        load_date(1900, 2, 28);
        add_days(1);                    // straight into march
        load_date(2024, 2, 29);
        add_days(-366);
        load_date(0, 1, 1);             // year zero
        load_date(cdda_pkg::YEAR_MAX + 1, 12, 31);
        send_request(cdda_pkg::CMD_LOAD, '1, '1, '1);  // every field at its top, day reads as the unsigned 1048575
        load_date(2021, 0, 5);
        load_date(2021, 13, 5);
        load_date(2021, 4, 0);
        load_date(2021, 4, 31);         // day past the month end
        load_date(1, 1, 1);
        add_days(-1);                   // falls before the first day
        add_days(524287);               // widest forward step
        add_days(-524288);              // widest backward step, underflows again
        load_date(cdda_pkg::YEAR_MAX, 12, 31);
        add_days(1);                    // past the last day: saturates
        add_days(524287);
        add_days(-524288);
        load_date(2000, 12, 31);
        add_days(1);                    // year roll
    endtask

    task automatic run_random();
        int unsigned stop_at;
        int unsigned wide_left;
        int unsigned pick;
        int unsigned n;
        stop_at   = requests_sent + RANDOM_ITEMS;
        wide_left = WIDE_ADJUSTS;
        while (requests_sent < stop_at) begin
            // now and then switch between idling and back-to-back traffic
            if ($urandom_range(0, 30) == 0) begin
                no_idle = ($urandom_range(0, 2) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // plain date followed by a run of adjustments from it
                load_date(pick_year(), $urandom_range(1, 12), pick_day());
                n = $urandom_range(1, 6);
                repeat (n) add_days(pick_delta());
            end else if (pick < 66) begin
                // close to the first day, walking backwards
                load_date($urandom_range(1, 2), $urandom_range(1, 12), pick_day());
                n = $urandom_range(1, 4);
                repeat (n) add_days(-int'($urandom_range(0, 800)));
            end else if (pick < 76) begin
                // close to the last day, walking forwards
                load_date(cdda_pkg::YEAR_MAX - $urandom_range(0, 1), $urandom_range(1, 12),
                          pick_day());
                n = $urandom_range(1, 4);
                repeat (n) add_days(int'($urandom_range(0, 800)));
            end else if (pick < 90) begin
                // raw field patterns, almost always an invalid load
                send_request(cdda_pkg::CMD_LOAD, cdda_pkg::YEAR_W'($urandom),
                             cdda_pkg::MONTH_W'($urandom), cdda_pkg::CNT_W'($urandom));
            end else if (pick < 96) begin
                add_days(signed_span(40000));
            end else if (pick < 98 && wide_left != 0) begin
                send_request(cdda_pkg::CMD_ADD, cdda_pkg::YEAR_W'($urandom),
                             cdda_pkg::MONTH_W'($urandom), cdda_pkg::CNT_W'($urandom));
                wide_left--;
            end else begin
                add_days(pick_delta());
            end
        end
    endtask

    initial begin : stimulus
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req_cmd   <= cdda_pkg::CMD_LOAD;
        req_year  <= '0;
        req_month <= '0;
        req_days  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random();
        req_valid <= 1'b0;

        // drain outstanding results, then give the block time to misbehave
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
